// File: hw/rtl/greedy_distance_thinning_core_macros.svh
// Assertion macros for the thinning core checker
`ifndef GREEDY_DISTANCE_THINNING_CORE_MACROS_SVH
`define GREEDY_DISTANCE_THINNING_CORE_MACROS_SVH

// same-cycle implication
`define GDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/gdt_pkg.sv
// Types and constants of the greedy distance thinning core
package gdt_pkg;
  localparam int CAPACITY_DEF   = 1024;
  localparam int COORD_BITS_DEF = 24;
  localparam int REDSHIFT_W     = 16;
  localparam int RADIUS_W       = 52;
  localparam int COUNT_W        = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 52;
  localparam int DRAIN_CYCLES   = 4;

  localparam logic [REDSHIFT_W-1:0] REDSHIFT_LOW_RST  = 16'd10650;
  localparam logic [REDSHIFT_W-1:0] REDSHIFT_HIGH_RST = 16'd12288;
  localparam logic [RADIUS_W-1:0]   RADIUS_SQ_RST     = 52'd6553600;

  localparam logic [CFG_IDX_W-1:0] REG_REDSHIFT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REDSHIFT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ     = 2'd2;

  localparam logic [1:0] STATUS_KEPT      = 2'd0;
  localparam logic [1:0] STATUS_OUT_RANGE = 2'd1;
  localparam logic [1:0] STATUS_COLLIDED  = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_REPORT} state_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;
endpackage

// File: hw/rtl/greedy_distance_thinning_core.sv
// Top level of the greedy distance thinning core
//
//  channel | signals                                       | handshake
//  --------+-----------------------------------------------+--------------------------
//  input   | first_object redshift x_pos y_pos z_pos       | start high, busy low
//  result  | status collided_total in_range_total          | done, one cycle, no stall
//  config  | cfg_index cfg_data                            | cfg_write, one cycle
//
// An item outside the redshift window goes from accept straight to the report
// state, then done is raised. For an item in the window, the kept objects rotate once
// round the chain of cells past the single distance unit, one per cycle, then
// its pipeline drains. Synchronous reset empties the store by clearing
// the fill count only; the cells themselves are never cleared.
// A new item may be started in the cycle that done is high.
module greedy_distance_thinning_core #(
  parameter int CAPACITY   = gdt_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = gdt_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic                           first_object,
  input  logic [gdt_pkg::REDSHIFT_W-1:0] redshift,
  input  logic [COORD_BITS-1:0]          x_pos,
  input  logic [COORD_BITS-1:0]          y_pos,
  input  logic [COORD_BITS-1:0]          z_pos,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [gdt_pkg::COUNT_W-1:0]    collided_total,
  output logic [gdt_pkg::COUNT_W-1:0]    in_range_total
);
  localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] LAST = CW'(CAPACITY - 1);
  localparam logic [KW-1:0] FULL = KW'(CAPACITY);

  gdt_pkg::state_t state, state_next;

  logic [gdt_pkg::REDSHIFT_W-1:0] redshift_low, redshift_high;
  logic [gdt_pkg::RADIUS_W-1:0]   radius_sq;
  logic [COORD_BITS-1:0]          qx, qy, qz;
  logic                           in_range_q, hit_acc, hit;
  logic [CW-1:0]                  cnt;
  logic [1:0]                     drain_cnt;
  logic [KW-1:0]                  kept_count;
  logic [gdt_pkg::COUNT_W-1:0]    collided_count, in_range_count;

  logic accept, in_range_now, issue, shift, write_new;

  logic [COORD_BITS-1:0] cx [CAPACITY];
  logic [COORD_BITS-1:0] cy [CAPACITY];
  logic [COORD_BITS-1:0] cz [CAPACITY];

  assign accept       = start && (state == gdt_pkg::ST_IDLE);
  assign in_range_now = (redshift >= redshift_low) && (redshift <= redshift_high);

  always_comb begin
    state_next = state;
    unique case (state)
      gdt_pkg::ST_IDLE:
        if (accept) state_next = in_range_now ? gdt_pkg::ST_SCAN : gdt_pkg::ST_REPORT;
      gdt_pkg::ST_SCAN:
        if (cnt == LAST) state_next = gdt_pkg::ST_DRAIN;
      gdt_pkg::ST_DRAIN:
        if (drain_cnt == 2'(gdt_pkg::DRAIN_CYCLES - 1)) state_next = gdt_pkg::ST_REPORT;
      gdt_pkg::ST_REPORT:
        state_next = gdt_pkg::ST_IDLE;
      default:
        state_next = gdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != gdt_pkg::ST_IDLE);
    shift     = (state == gdt_pkg::ST_SCAN);
    issue     = (state == gdt_pkg::ST_SCAN) && (KW'(cnt) < kept_count);
    write_new = (state == gdt_pkg::ST_REPORT) && in_range_q && !hit_acc
                && (kept_count < FULL);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int NB = (i + 1) % CAPACITY;
    gdt_pkg::cell_ctl_t ctl;
    assign ctl.shift = shift;
    assign ctl.write = write_new && (kept_count == KW'(i));
    gdt_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .nb_x (cx[NB]),
      .nb_y (cy[NB]),
      .nb_z (cz[NB]),
      .wr_x (qx),
      .wr_y (qy),
      .wr_z (qz),
      .x    (cx[i]),
      .y    (cy[i]),
      .z    (cz[i])
    );
  end

  gdt_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .valid     (issue),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .ex        (cx[0]),
    .ey        (cy[0]),
    .ez        (cz[0]),
    .radius_sq (radius_sq),
    .hit       (hit)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      qx         <= x_pos;
      qy         <= y_pos;
      qz         <= z_pos;
      in_range_q <= in_range_now;
      hit_acc    <= 1'b0;
      cnt        <= '0;
    end else begin
      hit_acc <= hit_acc | hit;
      if (state == gdt_pkg::ST_SCAN) cnt <= cnt + 1'b1;
    end
    if (state == gdt_pkg::ST_SCAN) drain_cnt <= '0;
    else if (state == gdt_pkg::ST_DRAIN) drain_cnt <= drain_cnt + 1'b1;
    if (state == gdt_pkg::ST_REPORT) begin
      if (!in_range_q)         status <= gdt_pkg::STATUS_OUT_RANGE;
      else if (hit_acc)        status <= gdt_pkg::STATUS_COLLIDED;
      else if (kept_count < FULL) status <= gdt_pkg::STATUS_KEPT;
      else                     status <= gdt_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= gdt_pkg::ST_IDLE;
      redshift_low   <= gdt_pkg::REDSHIFT_LOW_RST;
      redshift_high  <= gdt_pkg::REDSHIFT_HIGH_RST;
      radius_sq      <= gdt_pkg::RADIUS_SQ_RST;
      kept_count     <= '0;
      collided_count <= '0;
      in_range_count <= '0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == gdt_pkg::ST_REPORT);
      if (cfg_write) begin
        unique case (cfg_index)
          gdt_pkg::REG_REDSHIFT_LOW:  redshift_low  <= cfg_data[gdt_pkg::REDSHIFT_W-1:0];
          gdt_pkg::REG_REDSHIFT_HIGH: redshift_high <= cfg_data[gdt_pkg::REDSHIFT_W-1:0];
          gdt_pkg::REG_RADIUS_SQ:     radius_sq     <= cfg_data[gdt_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        // first object of a catalogue clears the store before counting
        if (first_object) begin
          kept_count     <= '0;
          collided_count <= '0;
          in_range_count <= in_range_now ? 32'd1 : 32'd0;
        end else if (in_range_now && (in_range_count != '1)) begin
          in_range_count <= in_range_count + 1'b1;
        end
      end
      if (state == gdt_pkg::ST_REPORT) begin
        if (in_range_q && hit_acc && (collided_count != '1))
          collided_count <= collided_count + 1'b1;
        if (write_new) kept_count <= kept_count + 1'b1;
      end
    end
  end

  assign collided_total = collided_count;
  assign in_range_total = in_range_count;
endmodule

// File: hw/rtl/gdt_cell.sv
// One storage cell of the rotating chain of kept objects
module gdt_cell #(
  parameter int COORD_BITS = gdt_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  gdt_pkg::cell_ctl_t    ctl,
  input  logic [COORD_BITS-1:0] nb_x,
  input  logic [COORD_BITS-1:0] nb_y,
  input  logic [COORD_BITS-1:0] nb_z,
  input  logic [COORD_BITS-1:0] wr_x,
  input  logic [COORD_BITS-1:0] wr_y,
  input  logic [COORD_BITS-1:0] wr_z,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y,
  output logic [COORD_BITS-1:0] z
);
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      x <= wr_x;
      y <= wr_y;
      z <= wr_z;
    end else if (ctl.shift) begin
      x <= nb_x;
      y <= nb_y;
      z <= nb_z;
    end
  end
endmodule

// File: hw/rtl/gdt_dist.sv
// Pipelined squared-distance compare against the collision radius
module gdt_dist #(
  parameter int COORD_BITS = gdt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  input  logic [COORD_BITS-1:0]        qx,
  input  logic [COORD_BITS-1:0]        qy,
  input  logic [COORD_BITS-1:0]        qz,
  input  logic [COORD_BITS-1:0]        ex,
  input  logic [COORD_BITS-1:0]        ey,
  input  logic [COORD_BITS-1:0]        ez,
  input  logic [gdt_pkg::RADIUS_W-1:0] radius_sq,
  output logic                         hit
);
  localparam int MW = COORD_BITS + 1;

  logic signed [MW-1:0] dx, dy, dz;
  logic [MW-1:0] mx, my, mz;
  logic [31:0] m1x, m1y, m1z;
  logic        big1, v1;
  logic [63:0] s2x, s2y, s2z;
  logic        big2, v2;
  logic [65:0] sum;

  assign dx = $signed({qx[COORD_BITS-1], qx}) - $signed({ex[COORD_BITS-1], ex});
  assign dy = $signed({qy[COORD_BITS-1], qy}) - $signed({ey[COORD_BITS-1], ey});
  assign dz = $signed({qz[COORD_BITS-1], qz}) - $signed({ez[COORD_BITS-1], ez});
  assign mx = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign my = dy[MW-1] ? MW'(-dy) : MW'(dy);
  assign mz = dz[MW-1] ? MW'(-dz) : MW'(dz);
  assign sum = 66'(s2x) + 66'(s2y) + 66'(s2z);

  always_ff @(posedge clk) begin
    m1x  <= 32'(mx);
    m1y  <= 32'(my);
    m1z  <= 32'(mz);
    // a magnitude of 2^32 or more squares past 64 bits: never a collision
    big1 <= (MW > 32) ? ((|(mx >> 32)) | (|(my >> 32)) | (|(mz >> 32))) : 1'b0;
    s2x  <= m1x * m1x;
    s2y  <= m1y * m1y;
    s2z  <= m1z * m1z;
    big2 <= big1;
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= valid;
      v2  <= v1;
      hit <= v2 && !big2 && (sum < 66'(radius_sq));
    end
  end
endmodule

// File: hw/rtl/gdt_checker.sv
// Port-level checker for the thinning core, with its bind
`include "greedy_distance_thinning_core_macros.svh"

module gdt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [1:0]                  status,
  input logic [gdt_pkg::COUNT_W-1:0] collided_total
);
  `GDT_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
  `GDT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")
  `GDT_ASSERT_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `GDT_ASSERT_IMP(a_coll_count, done && (status == gdt_pkg::STATUS_COLLIDED),
                  collided_total != '0, "collision reported with zero count")
endmodule

bind greedy_distance_thinning_core gdt_checker u_gdt_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .collided_total (collided_total)
);

// File: tb/tb_greedy_distance_thinning_core.sv
// Self-checking testbench for the greedy distance thinning core
module tb_greedy_distance_thinning_core;
  import gdt_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int CW = COORD_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  first_object = 1'b0;
  logic [REDSHIFT_W-1:0] redshift = '0;
  logic [CW-1:0]         x_pos = '0;
  logic [CW-1:0]         y_pos = '0;
  logic [CW-1:0]         z_pos = '0;
  logic                  done;
  logic [1:0]            status;
  logic [COUNT_W-1:0]    collided_total;
  logic [COUNT_W-1:0]    in_range_total;

  greedy_distance_thinning_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .first_object(first_object), .redshift(redshift),
    .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos),
    .done(done), .status(status),
    .collided_total(collided_total), .in_range_total(in_range_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] collided;
    logic [COUNT_W-1:0] in_range;
  } verdict_t;

  verdict_t verdict_q[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;

  // own copy of the block's registers and store
  logic [REDSHIFT_W-1:0] win_low = REDSHIFT_LOW_RST;
  logic [REDSHIFT_W-1:0] win_high = REDSHIFT_HIGH_RST;
  logic [RADIUS_W-1:0]   rad_sq = RADIUS_SQ_RST;
  logic signed [CW-1:0]  kept_xs[CAP];
  logic signed [CW-1:0]  kept_ys[CAP];
  logic signed [CW-1:0]  kept_zs[CAP];
  int                    n_kept = 0;
  logic [COUNT_W-1:0]    n_collided = '0;
  logic [COUNT_W-1:0]    n_in_range = '0;

  function automatic verdict_t thin_object(bit first, logic [REDSHIFT_W-1:0] rs,
                                           logic signed [CW-1:0] px,
                                           logic signed [CW-1:0] py,
                                           logic signed [CW-1:0] pz);
    verdict_t v;
    bit hit;
    longint dx, dy, dz;
    longint unsigned sq_sum;
    hit = 1'b0;
    if (first) begin
      n_kept = 0;
      n_collided = '0;
      n_in_range = '0;
    end
    if (rs < win_low || rs > win_high) begin
      v.status = STATUS_OUT_RANGE;
    end else begin
      if (n_in_range != '1) n_in_range++;
      for (int k = 0; k < n_kept && !hit; k++) begin
        dx = longint'(px) - longint'(kept_xs[k]);
        dy = longint'(py) - longint'(kept_ys[k]);
        dz = longint'(pz) - longint'(kept_zs[k]);
        // differences fit 25 bits, so the sum cannot overflow 64 bits
        sq_sum = dx * dx + dy * dy + dz * dz;
        if (sq_sum < {12'd0, rad_sq}) hit = 1'b1;
      end
      if (hit) begin
        if (n_collided != '1) n_collided++;
        v.status = STATUS_COLLIDED;
      end else if (n_kept < CAP) begin
        kept_xs[n_kept] = px;
        kept_ys[n_kept] = py;
        kept_zs[n_kept] = pz;
        n_kept++;
        v.status = STATUS_KEPT;
      end else begin
        v.status = STATUS_FULL;
      end
    end
    v.collided = n_collided;
    v.in_range = n_in_range;
    return v;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0d, wanted %0d", $time, what, got, want);
    mismatches++;
  endtask

  // results and watchdog
  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done) begin
        if (verdict_q.size() == 0) begin
          report("unexpected item, status", status, 0);
        end else begin
          v = verdict_q.pop_front();
          if (status !== v.status) report("status", status, v.status);
          if (collided_total !== v.collided) report("collided_total", collided_total, v.collided);
          if (in_range_total !== v.in_range) report("in_range_total", in_range_total, v.in_range);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(bit first, logic [REDSHIFT_W-1:0] rs,
                           logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                           bit typed, logic [1:0] typed_status, bit no_gap);
    int gap;
    verdict_t v;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    first_object <= first;
    redshift <= rs;
    x_pos <= px;
    y_pos <= py;
    z_pos <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    v = thin_object(first, rs, px, py, pz);
    if (typed) v.status = typed_status;
    verdict_q.push_back(v);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_REDSHIFT_LOW:  win_low = val[REDSHIFT_W-1:0];
      REG_REDSHIFT_HIGH: win_high = val[REDSHIFT_W-1:0];
      REG_RADIUS_SQ:     rad_sq = val[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_window(int lo, int hi, logic [RADIUS_W-1:0] r2);
    write_reg(REG_REDSHIFT_LOW, CFG_DATA_W'(lo));
    write_reg(REG_REDSHIFT_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_RADIUS_SQ, CFG_DATA_W'(r2));
  endtask

  task automatic random_object(bit force_first);
    logic [REDSHIFT_W-1:0] rs;
    logic [CW-1:0] c[3];
    logic signed [CW-1:0] base;
    int r, idx;
    r = $urandom_range(0, 99);
    if (r < 45 && win_low <= win_high) rs = REDSHIFT_W'($urandom_range(win_low, win_high));
    else if (r < 50) rs = win_low;
    else if (r < 55) rs = win_high;
    else rs = REDSHIFT_W'($urandom);
    for (int j = 0; j < 3; j++) begin
      if (n_kept > 0 && $urandom_range(0, 1)) begin
        // land near a kept object so collisions and near misses happen
        idx = $urandom_range(0, n_kept - 1);
        base = (j == 0) ? kept_xs[idx] : (j == 1) ? kept_ys[idx] : kept_zs[idx];
        c[j] = base + CW'($urandom_range(0, 6000)) - CW'(3000);
      end else begin
        c[j] = CW'($urandom);
      end
    end
    send_item(force_first || $urandom_range(0, 39) == 0, rs, c[0], c[1], c[2],
              1'b0, STATUS_KEPT, 1'b0);
  endtask

  typedef struct {
    bit         first;
    int         rs;
    int         px, py, pz;
    bit         typed;
    logic [1:0] st;
  } dir_row_t;

  // reset window 10650..12288, radius squared 2560^2
  dir_row_t dir_rows[15] = '{
    '{1, 10650, 0, 0, 0, 1, STATUS_KEPT},
    '{0, 10649, 0, 0, 0, 1, STATUS_OUT_RANGE},
    '{0, 12289, 0, 0, 0, 1, STATUS_OUT_RANGE},
    '{0, 0, 0, 0, 0, 1, STATUS_OUT_RANGE},
    '{0, 65535, 0, 0, 0, 1, STATUS_OUT_RANGE},
    '{0, 12288, 2559, 0, 0, 1, STATUS_COLLIDED},
    '{0, 12288, 2560, 0, 0, 1, STATUS_KEPT},
    '{0, 11000, 8388607, -8388608, 8388607, 1, STATUS_KEPT},
    '{0, 11000, -8388608, 8388607, -8388608, 1, STATUS_KEPT},
    '{0, 11000, 8388607, -8388608, 8388606, 1, STATUS_COLLIDED},
    '{0, 11000, 5120, 0, 0, 1, STATUS_KEPT},
    '{1, 11000, 2559, 0, 0, 1, STATUS_KEPT},
    '{0, 11000, 0, 0, 0, 1, STATUS_COLLIDED},
    '{0, 11000, -1, -1, -1, 0, STATUS_KEPT},
    '{0, 12000, 0, 2000, 1500, 0, STATUS_KEPT}
  };

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].first, REDSHIFT_W'(dir_rows[i].rs), CW'(dir_rows[i].px),
                CW'(dir_rows[i].py), CW'(dir_rows[i].pz), dir_rows[i].typed,
                dir_rows[i].st, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_window(REDSHIFT_LOW_RST, REDSHIFT_HIGH_RST, RADIUS_SQ_RST);
        1: set_window(0, 65535, 52'd26214400);
        2: set_window(20000, 19999, RADIUS_SQ_RST);   // empty window
        3: set_window(0, 65535, '0);                   // nothing collides
        4: set_window(30000, 30000, '1);               // all in-window objects after the first collide
        default: begin
          int a, b;
          a = $urandom_range(0, 65535);
          b = $urandom_range(0, 65535);
          set_window(a < b ? a : b, a < b ? b : a,
                     RADIUS_W'({$urandom, $urandom}) >> $urandom_range(4, 30));
        end
      endcase
      for (int i = 0; i < 95; i++) random_object(i == 0);
    end

    set_window(REDSHIFT_LOW_RST, REDSHIFT_HIGH_RST, RADIUS_SQ_RST);
    for (int i = 0; i < 10; i++) random_object(i == 0);

    wait_idle();
    repeat (DRAIN_CYCLES + 8) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
